// File: rtl/core/stia_pkg.sv
// stia_pkg: shared types and constants for the session table with idle aging
// depends on nothing; imported by every module of the block

package stia_pkg;

    // sizing
    localparam int SessionsDefault = 16;
    localparam int MaxResults      = 16;
    localparam int FrontDepth      = 4;
    localparam int OutDepth        = 4;

    // input command codes
    localparam logic [1:0] CmdPacket = 2'd0;
    localparam logic [1:0] CmdReply  = 2'd1;
    localparam logic [1:0] CmdTick   = 2'd2;

    // result action codes
    localparam logic [2:0] ActToDest    = 3'd0;
    localparam logic [2:0] ActToClient  = 3'd1;
    localparam logic [2:0] ActFullDrop  = 3'd2;
    localparam logic [2:0] ActNoSession = 3'd3;
    localparam logic [2:0] ActExpired   = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] stream_id;
        logic [3:0]  session_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [31:0] result_stream_id;
        logic        newly_opened;
        logic        last;
    } t_result;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_PACKET = 3'b001,
        OP_REPLY  = 3'b010,
        OP_TICK   = 3'b100
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] stream_id;
        logic [3:0]  session_index;
    } t_job;

endpackage

// File: rtl/core/session_table_idle_aging.sv
// session_table_idle_aging: top level of the session table with idle aging
// depends on stia_pkg, stia_front, stia_back
//
// Usage:
//   Input channel is a queue write port: an item (command, stream_id,
//   session_index) is taken on a clock edge with push high and full low.
//   Results come out of a queue read port: while empty is low the oldest
//   result sits on o_result and is taken on an edge with pop high.
//   A client packet or a reply gives exactly one result; with the back end
//   free the item is registered in the front queue, then its result in the
//   result queue. Packets and replies run at one item per cycle while the
//   back end is idle and the result queue has room, set by the combinational
//   parallel match over all SESSIONS entries. A tick walks the table one entry
//   per cycle while the result queue has room, giving zero to 16 expiry
//   results, the final one flagged last. Unknown commands are taken and dropped.
//   Items keep flowing into a four-deep front queue while the back end
//   sweeps or waits on a stalled receiver; full rises once that queue fills.
//   Synchronous reset empties both queues and clears all valid and active
//   marks at once; the block can take items once reset is released.

module session_table_idle_aging
    import stia_pkg::*;
#(
    parameter int SESSIONS = SessionsDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    logic job_valid;
    logic job_take;
    t_job job;

    // accept and classify
    stia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    // table execution and results
    stia_back #(
        .SESSIONS (SESSIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_empty     (empty),
        .o_result    (o_result),
        .pop         (pop)
    );

endmodule

// File: rtl/core/stia_front.sv
// stia_front: accepts items, classifies the command and queues jobs for the back end
// depends on stia_pkg

module stia_front
    import stia_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_take
);

    localparam int PtrW = $clog2(FrontDepth);
    localparam int CntW = $clog2(FrontDepth + 1);

    t_job            r_q [FrontDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic            known;
    logic            wr_en;
    logic            rd_en;
    t_job            job_in;

    // classify: unknown commands are accepted and dropped here
    always_comb begin
        known            = 1'b1;
        job_in.op        = OP_PACKET;
        job_in.stream_id = i_item.stream_id;
        job_in.session_index = i_item.session_index;
        case (i_item.command)
            CmdPacket: job_in.op = OP_PACKET;
            CmdReply:  job_in.op = OP_REPLY;
            CmdTick:   job_in.op = OP_TICK;
            default:   known = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == CntW'(FrontDepth));
    assign wr_en       = push && !o_full && known;
    assign o_job_valid = (r_cnt != '0);
    assign rd_en       = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rd];
    assign n_cnt       = r_cnt + CntW'(wr_en) - CntW'(rd_en);

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr <= r_wr + PtrW'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + PtrW'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= job_in;
        end
    end

endmodule

// File: rtl/core/stia_back.sv
// stia_back: session table, lookup, reply handling, aging sweep and result queue
// depends on stia_pkg

module stia_back
    import stia_pkg::*;
#(
    parameter int SESSIONS = SessionsDefault
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_take,
    output logic    o_empty,
    output t_result o_result,
    input  logic    pop
);

    localparam int IW   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int NW   = $clog2(MaxResults + 1);
    localparam int OPW  = $clog2(OutDepth);
    localparam int OCW  = $clog2(OutDepth + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    // table
    logic [SESSIONS-1:0] r_valid;
    logic [SESSIONS-1:0] r_active;
    logic [31:0]         r_stream [SESSIONS];

    // sequencer
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [NW-1:0] r_n, n_n;
    logic          r_pend_vld, n_pend_vld;
    t_result       r_pend, n_pend;

    // result queue
    t_result         r_oq [OutDepth];
    logic [OPW-1:0]  r_owr;
    logic [OPW-1:0]  r_ord;
    logic [OCW-1:0]  r_ocnt;
    logic            out_full;
    logic            pop_ok;

    // lookup and control
    logic          hit_found;
    logic [IW-1:0] hit_idx;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] rd_idx;
    logic [31:0]   rd_stream;
    logic          reply_ok;
    logic          step;
    logic          res_push;
    t_result       res_data;
    logic          open_en;
    logic          act_set;
    logic [IW-1:0] act_idx;
    logic          act_clr;
    logic          free_en;

    // parallel match and lowest free slot
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SESSIONS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_stream[i] == i_job.stream_id)) begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // single read port: sweep position or reply slot
    assign rd_idx    = (r_state == S_SWEEP) ? r_idx : IW'(i_job.session_index);
    assign rd_stream = r_stream[rd_idx];
    assign reply_ok  = (32'(i_job.session_index) < 32'(SESSIONS)) && r_valid[rd_idx];

    assign out_full = (r_ocnt == OCW'(OutDepth));
    assign step     = !out_full;
    assign pop_ok   = pop && !o_empty;

    // sequencer next state and table controls
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_n        = r_n;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        o_job_take = 1'b0;
        res_push   = 1'b0;
        res_data   = '0;
        open_en    = 1'b0;
        act_set    = 1'b0;
        act_idx    = rd_idx;
        act_clr    = 1'b0;
        free_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid && step) begin
                    o_job_take    = 1'b1;
                    res_data.last = 1'b1;
                    case (i_job.op)
                        OP_PACKET: begin
                            res_push                  = 1'b1;
                            res_data.result_stream_id = i_job.stream_id;
                            if (hit_found) begin
                                res_data.action = ActToDest;
                                res_data.slot   = 4'(hit_idx);
                                act_set         = 1'b1;
                                act_idx         = hit_idx;
                            end else if (free_found) begin
                                res_data.action       = ActToDest;
                                res_data.slot         = 4'(free_idx);
                                res_data.newly_opened = 1'b1;
                                open_en               = 1'b1;
                                act_set               = 1'b1;
                                act_idx               = free_idx;
                            end else begin
                                res_data.action = ActFullDrop;
                            end
                        end
                        OP_REPLY: begin
                            res_push      = 1'b1;
                            res_data.slot = i_job.session_index;
                            if (reply_ok) begin
                                res_data.action           = ActToClient;
                                res_data.result_stream_id = rd_stream;
                                act_set                   = 1'b1;
                            end else begin
                                res_data.action = ActNoSession;
                            end
                        end
                        OP_TICK: begin
                            n_state    = S_SWEEP;
                            n_idx      = '0;
                            n_n        = '0;
                            n_pend_vld = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                if (step) begin
                    if (r_valid[r_idx]) begin
                        if (r_active[r_idx]) begin
                            act_clr = 1'b1;
                        end else if (r_n < NW'(MaxResults)) begin
                            // an expiry waits for the next so the final one can carry last
                            free_en                 = 1'b1;
                            n_n                     = r_n + NW'(1);
                            res_push                = r_pend_vld;
                            res_data                = r_pend;
                            n_pend_vld              = 1'b1;
                            n_pend                  = '0;
                            n_pend.action           = ActExpired;
                            n_pend.slot             = 4'(r_idx);
                            n_pend.result_stream_id = rd_stream;
                        end
                    end
                    if (r_idx == IW'(SESSIONS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (step) begin
                    res_push      = r_pend_vld;
                    res_data      = r_pend;
                    res_data.last = 1'b1;
                    n_pend_vld    = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_n        <= '0;
            r_pend_vld <= 1'b0;
            r_valid    <= '0;
            r_active   <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_n        <= n_n;
            r_pend_vld <= n_pend_vld;
            if (open_en) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (free_en) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (act_set) begin
                r_active[act_idx] <= 1'b1;
            end
            if (act_clr) begin
                r_active[r_idx] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (open_en) begin
            r_stream[free_idx] <= i_job.stream_id;
        end
    end

    // result queue
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= r_ocnt + OCW'(res_push) - OCW'(pop_ok);
            if (res_push) begin
                r_owr <= r_owr + OPW'(1);
            end
            if (pop_ok) begin
                r_ord <= r_ord + OPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owr] <= res_data;
        end
    end

endmodule

// File: rtl/core/stia_checker.sv
// stia_checker: port-level assertions for session_table_idle_aging, bound to the top
// depends on stia_pkg

module stia_checker
    import stia_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     push,
    input t_in_item i_item,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input t_result  o_result
);

    // the result queue comes out of reset empty and the front queue not full
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // only an opened session carries newly_opened, and only on a forward
    a_opened_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.newly_opened) |-> (o_result.action == ActToDest && o_result.last))
        else $error("newly_opened on a result that is not a forward");

    // packets and replies give exactly one result, so it must be last
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.action != ActExpired) |-> o_result.last)
        else $error("non-expiry result without last");

    // a full-table drop reports slot zero
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.action == ActFullDrop) |-> (o_result.slot == 4'd0))
        else $error("full drop with nonzero slot");

    // a waiting result holds while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while stalled");

endmodule

bind session_table_idle_aging stia_checker u_stia_checker (.*);
